### hdl/ttt_pkg.sv
package ttt_pkg;
  localparam int SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam int RES_W = 20;
  localparam logic [RES_W-1:0] RES_RESET = 20'd10000;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_REG = 2'd1;
  localparam logic [1:0] OP_DEREG = 2'd2;
  localparam logic [1:0] OP_EXPIRE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOINIT = 2'd1;
  localparam logic [1:0] ST_INACTIVE = 2'd2;
  localparam logic [1:0] ST_BUSY = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] slot;
    logic fire_once;
    logic [31:0] period_usec;
    logic [63:0] start_time_usec;
    logic [63:0] now_usec;
    logic signed [31:0] callback_arg;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic [1:0] status;
    logic [3:0] fired_slot;
    logic signed [31:0] fired_arg;
    logic last;
  } out_item_t;

  // Request to and answer from the shared serial divider.
  typedef struct packed {
    logic start;
    logic [63:0] dividend;
    logic [RES_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage

### hdl/ttt_if.sv
interface ttt_in_if (input logic clk);
  logic valid;
  logic ready;
  ttt_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ttt_out_if (input logic clk);
  logic valid;
  logic ready;
  ttt_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/ttt_div.sv
module ttt_div (
  input  logic clk,
  input  logic rst_n,
  input  ttt_pkg::div_req_t req,
  output ttt_pkg::div_rsp_t rsp
);
  // Restoring division, one quotient bit per cycle.
  logic [63:0] quo_r, quo_nxt;
  logic [ttt_pkg::RES_W:0] rem_r, rem_nxt;
  logic [ttt_pkg::RES_W-1:0] dvs_r, dvs_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [ttt_pkg::RES_W+1:0] trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, quo_r[63]} - {2'b0, dvs_r};
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[ttt_pkg::RES_W+1]) begin
        rem_nxt = trial[ttt_pkg::RES_W:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[ttt_pkg::RES_W-1:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;
endmodule

### hdl/ttt_seq.sv
module ttt_seq (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [ttt_pkg::RES_W-1:0] cfg_wdata,
  ttt_in_if.sink in_ch,
  ttt_out_if.source out_ch,
  output ttt_pkg::div_req_t div_req,
  input  ttt_pkg::div_rsp_t div_rsp
);
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DEC    = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_RELOAD = 8'b0000_1000,
    S_REGDIV = 8'b0001_0000,
    S_EMIT   = 8'b0010_0000,
    S_WAIT   = 8'b0100_0000,
    S_DIVW   = 8'b1000_0000
  } state_t;

  state_t st_r, st_nxt;
  logic [ttt_pkg::RES_W-1:0] res_r;
  logic [ttt_pkg::SLOTS-1:0] act_r;
  logic [ttt_pkg::SLOTS-1:0] oneshot_mem;
  logic [31:0] period_mem [ttt_pkg::SLOTS];
  logic [63:0] count_mem [ttt_pkg::SLOTS];
  logic [31:0] arg_mem [ttt_pkg::SLOTS];
  ttt_pkg::in_item_t item_r;
  ttt_pkg::out_item_t obuf_r;
  logic ovalid_r;
  logic [ttt_pkg::SLOT_W:0] idx_r;
  logic [4:0] nrep_r;
  logic [ttt_pkg::SLOT_W-1:0] ix;
  logic [31:0] clamp_p;
  logic [63:0] gap_usec;
  logic dec_done;
  logic [4:0] nrep_inc;
  logic after_last;
  logic scan_end, scan_hit, div_kick;
  logic [1:0] acc_status;
  logic [ttt_pkg::SLOT_W-1:0] acc_slot;

  assign ix = idx_r[ttt_pkg::SLOT_W-1:0];
  assign clamp_p = (item_r.period_usec < {12'd0, res_r}) ? {12'd0, res_r}
                                                          : item_r.period_usec;
  assign gap_usec = item_r.start_time_usec - item_r.now_usec;
  assign in_ch.ready = (st_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = obuf_r;
  assign dec_done = idx_r == (ttt_pkg::SLOT_W+1)'(ttt_pkg::SLOTS - 1);
  assign nrep_inc = nrep_r + 5'd1;
  assign scan_end = idx_r == (ttt_pkg::SLOT_W+1)'(ttt_pkg::SLOTS);
  assign scan_hit = act_r[ix] && count_mem[ix] == 64'd0 && nrep_r < 5'd16;
  assign div_kick = (st_r == S_REGDIV) ||
                    (st_r == S_SCAN && !ovalid_r && !scan_end && scan_hit &&
                     !oneshot_mem[ix]);

  // Is there another expiring slot beyond ix? Decides the last flag.
  always_comb begin
    after_last = 1'b1;
    for (int j = 0; j < ttt_pkg::SLOTS; j++)
      if (j > int'(ix) && act_r[j] && count_mem[j] == 64'd0 && nrep_inc < 5'd16)
        after_last = 1'b0;
  end

  // Status and slot of the answer to a command being accepted.
  always_comb begin
    acc_slot = (in_ch.data.operation == ttt_pkg::OP_TICK) ? '0 : in_ch.data.slot;
    if (res_r == '0) acc_status = ttt_pkg::ST_NOINIT;
    else if (in_ch.data.operation == ttt_pkg::OP_TICK) acc_status = ttt_pkg::ST_OK;
    else if (in_ch.data.operation == ttt_pkg::OP_REG)
      acc_status = act_r[in_ch.data.slot] ? ttt_pkg::ST_BUSY : ttt_pkg::ST_OK;
    else acc_status = act_r[in_ch.data.slot] ? ttt_pkg::ST_OK : ttt_pkg::ST_INACTIVE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_req.start <= 1'b0;
      st_r <= S_IDLE;
      res_r <= ttt_pkg::RES_RESET;
      act_r <= '0;
      ovalid_r <= 1'b0;
      idx_r <= '0;
      nrep_r <= '0;
    end else begin
      div_req.start <= div_kick;
      if (cfg_we) res_r <= cfg_wdata;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item_r <= in_ch.data;
            obuf_r <= '{ttt_pkg::KIND_STATUS, acc_status, acc_slot, 32'sd0, 1'b1};
            idx_r <= '0;
            nrep_r <= '0;
            if (res_r == '0) begin
              ovalid_r <= 1'b1;
            end else if (in_ch.data.operation == ttt_pkg::OP_TICK) begin
              st_r <= S_DEC;
            end else if (in_ch.data.operation == ttt_pkg::OP_REG) begin
              if (act_r[in_ch.data.slot]) begin
                ovalid_r <= 1'b1;
              end else begin
                st_r <= S_REGDIV;
              end
            end else begin
              if (act_r[in_ch.data.slot]) begin
                if (in_ch.data.operation == ttt_pkg::OP_DEREG)
                  act_r[in_ch.data.slot] <= 1'b0;
                else count_mem[in_ch.data.slot] <= 64'd0;
              end
              ovalid_r <= 1'b1;
            end
          end
        end
        S_DEC: begin
          if (act_r[ix] && count_mem[ix] != 64'd0) count_mem[ix] <= count_mem[ix] - 64'd1;
          idx_r <= dec_done ? '0 : idx_r + 1'b1;
          if (dec_done) st_r <= S_SCAN;
        end
        S_SCAN: begin
          if (!ovalid_r) begin
            if (scan_end) begin
              if (nrep_r == 5'd0) ovalid_r <= 1'b1;
              st_r <= S_WAIT;
            end else if (scan_hit) begin
              obuf_r <= '{ttt_pkg::KIND_EXPIRY, ttt_pkg::ST_OK, ix, arg_mem[ix], after_last};
              ovalid_r <= 1'b1;
              nrep_r <= nrep_inc;
              if (oneshot_mem[ix]) begin
                act_r[ix] <= 1'b0;
                idx_r <= idx_r + 1'b1;
              end else begin
                div_req.dividend <= {32'd0, period_mem[ix]};
                div_req.divisor <= res_r;
                st_r <= S_RELOAD;
              end
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_RELOAD: begin
          if (div_rsp.done) begin
            count_mem[ix] <= div_rsp.quotient;
            idx_r <= idx_r + 1'b1;
            st_r <= S_SCAN;
          end
        end
        S_REGDIV: begin
          div_req.divisor <= res_r;
          if (item_r.now_usec < item_r.start_time_usec)
            div_req.dividend <= gap_usec;
          else div_req.dividend <= {32'd0, clamp_p};
          st_r <= S_DIVW;
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            if (item_r.now_usec < item_r.start_time_usec && gap_usec <= {44'd0, res_r})
              count_mem[item_r.slot] <= 64'd1;
            else count_mem[item_r.slot] <= div_rsp.quotient;
            act_r[item_r.slot] <= 1'b1;
            oneshot_mem[item_r.slot] <= item_r.fire_once;
            period_mem[item_r.slot] <= clamp_p;
            arg_mem[item_r.slot] <= item_r.callback_arg;
            ovalid_r <= 1'b1;
            st_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!ovalid_r || (out_ch.valid && out_ch.ready)) st_r <= S_IDLE;
        end
        S_EMIT: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/tick_timer_table_unit.sv
// Tick timer table: sixteen timer slots, one-shot or periodic.
// Input channel in_*: one beat carries a command (tick, register,
// deregister, force expiry) with its fields. Result channel out_*:
// beats of status or expiry reports; last marks the final beat of a
// command. cfg_we/cfg_wdata write the tick resolution in microseconds.
// A register command runs the serial divider and its answer is valid
// once the division is done. A tick walks all sixteen slots to
// decrement them, then scans them again, one slot a cycle while no
// result beat waits and no reload division runs. Each periodic timer
// that expires is reloaded through the divider, each one-shot is
// cleared. Deregister and force expiry answer the cycle after acceptance.
// One command at a time is in work; in_ready stays low until its last
// beat is taken. A stalled receiver holds the current beat and the scan
// waits. Reset clears all slots and sets the resolution to 10000.
module tick_timer_table_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [ttt_pkg::RES_W-1:0] cfg_wdata,
  ttt_in_if.sink in_ch,
  ttt_out_if.source out_ch
);
  ttt_pkg::div_req_t div_req;
  ttt_pkg::div_rsp_t div_rsp;

  ttt_seq u_seq (.clk, .rst_n, .cfg_we, .cfg_wdata, .in_ch, .out_ch,
                 .div_req, .div_rsp);
  ttt_div u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));
endmodule

### hdl/ttt_checker.sv
module ttt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input ttt_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready during output");
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("double accept");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == ttt_pkg::KIND_STATUS |-> out_data.last)
    else $error("status not last");
endmodule

bind tick_timer_table_unit ttt_checker u_chk (.clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_data(out_ch.data));

### test/tb_if.sv
`timescale 1ns / 100ps

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ttt_pkg::RES_W-1:0] cfg_wdata = '0;

  ttt_in_if in_ch (clk);
  ttt_out_if out_ch (clk);

  tick_timer_table_unit i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the timer table.
  logic [ttt_pkg::RES_W-1:0] tick_res;
  logic       tbl_active [ttt_pkg::SLOTS];
  logic       tbl_fire_once [ttt_pkg::SLOTS];
  logic [31:0] tbl_period [ttt_pkg::SLOTS];
  logic [63:0] tbl_count [ttt_pkg::SLOTS];
  logic [31:0] tbl_arg [ttt_pkg::SLOTS];

  ttt_pkg::in_item_t  cmd_q [$];
  ttt_pkg::out_item_t expected_beats [$];
  int errors = 0;
  int sent = 0;
  bit quiet = 1'b0;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic ttt_pkg::out_item_t beat(logic k, logic [1:0] st, logic [3:0] s,
                                              logic [31:0] a, logic l);
    ttt_pkg::out_item_t b;
    b.kind = k; b.status = st; b.fired_slot = s; b.fired_arg = a; b.last = l;
    return b;
  endfunction

  // Applies one command to the shadow table and queues the beats it causes.
  task automatic predict_timers(input ttt_pkg::in_item_t c);
    logic [31:0] p;
    logic [63:0] d;
    int n;
    n = 0;
    if (tick_res == '0) begin
      expected_beats.push_back(beat(ttt_pkg::KIND_STATUS, ttt_pkg::ST_NOINIT,
        c.operation == ttt_pkg::OP_TICK ? 4'd0 : c.slot, 32'd0, 1'b1));
      return;
    end
    case (c.operation)
      ttt_pkg::OP_TICK: begin
        for (int i = 0; i < ttt_pkg::SLOTS; i++)
          if (tbl_active[i] && tbl_count[i] != 64'd0) tbl_count[i]--;
        for (int i = 0; i < ttt_pkg::SLOTS; i++) begin
          if (!tbl_active[i] || tbl_count[i] != 64'd0) continue;
          expected_beats.push_back(beat(ttt_pkg::KIND_EXPIRY, ttt_pkg::ST_OK, i[3:0],
                                        tbl_arg[i], 1'b0));
          n++;
          if (tbl_fire_once[i]) tbl_active[i] = 1'b0;
          else tbl_count[i] = 64'(tbl_period[i] / 32'(tick_res));
        end
        if (n == 0)
          expected_beats.push_back(beat(ttt_pkg::KIND_STATUS, ttt_pkg::ST_OK, 4'd0, 32'd0,
                                        1'b1));
        else expected_beats[$].last = 1'b1;
      end
      ttt_pkg::OP_REG: begin
        if (tbl_active[c.slot]) begin
          expected_beats.push_back(beat(ttt_pkg::KIND_STATUS, ttt_pkg::ST_BUSY, c.slot,
                                        32'd0, 1'b1));
        end else begin
          p = (c.period_usec < 32'(tick_res)) ? 32'(tick_res) : c.period_usec;
          if (c.now_usec < c.start_time_usec) begin
            d = c.start_time_usec - c.now_usec;
            tbl_count[c.slot] = (64'(tick_res) < d) ? d / 64'(tick_res) : 64'd1;
          end else begin
            tbl_count[c.slot] = 64'(p / 32'(tick_res));
          end
          tbl_active[c.slot] = 1'b1;
          tbl_fire_once[c.slot] = c.fire_once;
          tbl_period[c.slot] = p;
          tbl_arg[c.slot] = c.callback_arg;
          expected_beats.push_back(beat(ttt_pkg::KIND_STATUS, ttt_pkg::ST_OK, c.slot,
                                        32'd0, 1'b1));
        end
      end
      default: begin
        if (!tbl_active[c.slot]) begin
          expected_beats.push_back(beat(ttt_pkg::KIND_STATUS, ttt_pkg::ST_INACTIVE, c.slot,
                                        32'd0, 1'b1));
        end else begin
          if (c.operation == ttt_pkg::OP_DEREG) tbl_active[c.slot] = 1'b0;
          else tbl_count[c.slot] = 64'd0;
          expected_beats.push_back(beat(ttt_pkg::KIND_STATUS, ttt_pkg::ST_OK, c.slot,
                                        32'd0, 1'b1));
        end
      end
    endcase
  endtask

  // Driver: pulls commands from the queue, with random idle bursts.
  int src_idle = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the beat
    end else begin
      if (in_ch.valid) begin
        predict_timers(in_ch.data);
        sent++;
      end
      if (src_idle > 0) begin
        src_idle--;
        in_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        src_idle = $urandom_range(0, 15);
        in_ch.valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        in_ch.data <= cmd_q.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every accepted result beat; ready idles in bursts.
  int snk_idle = 0;
  ttt_pkg::out_item_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = expected_beats.pop_front();
          if (out_ch.data.kind !== want.kind)
            report($sformatf("kind %0d, want %0d", out_ch.data.kind, want.kind));
          if (out_ch.data.status !== want.status)
            report($sformatf("status %0d, want %0d", out_ch.data.status, want.status));
          if (out_ch.data.fired_slot !== want.fired_slot)
            report($sformatf("slot %0d, want %0d", out_ch.data.fired_slot,
                             want.fired_slot));
          if (out_ch.data.fired_arg !== want.fired_arg)
            report($sformatf("arg %0d, want %0d", out_ch.data.fired_arg, want.fired_arg));
          if (out_ch.data.last !== want.last)
            report($sformatf("last %0d, want %0d", out_ch.data.last, want.last));
        end
      end
      if (snk_idle > 0) begin
        snk_idle--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        snk_idle = $urandom_range(0, 15);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic ttt_pkg::in_item_t make_cmd(int op, int s, int os,
                                                 logic [31:0] per, logic [63:0] st,
                                                 logic [63:0] nw, logic [31:0] a);
    ttt_pkg::in_item_t c;
    c.operation = 2'(op); c.slot = 4'(s); c.fire_once = 1'(os); c.period_usec = per;
    c.start_time_usec = st; c.now_usec = nw; c.callback_arg = a;
    return c;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random command; mostly ticks and registrations, most of the latter with
  // short periods so that timers expire often, plus slot operations.
  function automatic ttt_pkg::in_item_t rand_cmd();
    int r;
    logic [63:0] nw;
    r = $urandom_range(0, 99);
    nw = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom());
    if (r < 45) return make_cmd(ttt_pkg::OP_TICK, $urandom(), $urandom(), $urandom(),
                                 rand64(), rand64(), $urandom());
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0: return make_cmd(ttt_pkg::OP_REG, $urandom(), $urandom(), $urandom(), rand64(),
                           rand64(), $urandom());
        1: return make_cmd(ttt_pkg::OP_REG, $urandom(), $urandom(),
                           $urandom_range(0, 60000), nw + 64'($urandom_range(0, 80000)),
                           nw, $urandom());
        default: return make_cmd(ttt_pkg::OP_REG, $urandom(), $urandom(),
                                 $urandom_range(0, 60000), 64'd0, nw, $urandom());
      endcase
    end
    if (r < 87) return make_cmd(ttt_pkg::OP_EXPIRE, $urandom(), $urandom(), $urandom(),
                                rand64(), rand64(), $urandom());
    return make_cmd(ttt_pkg::OP_DEREG, $urandom(), $urandom(), $urandom(), rand64(),
                    rand64(), $urandom());
  endfunction

  task automatic drain();
    while (cmd_q.size() > 0 || in_ch.valid || expected_beats.size() > 0 || !in_ch.ready)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_res(input logic [ttt_pkg::RES_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_res = v;
  endtask

  initial begin
    tick_res = ttt_pkg::RES_RESET;
    for (int i = 0; i < ttt_pkg::SLOTS; i++) begin
      tbl_active[i] = 1'b0; tbl_fire_once[i] = 1'b0; tbl_period[i] = '0;
      tbl_count[i] = '0; tbl_arg[i] = '0;
    end
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset resolution.
    cmd_q.push_back(make_cmd(ttt_pkg::OP_TICK, 15, 1, '1, '1, '1, '1));
    cmd_q.push_back(make_cmd(ttt_pkg::OP_REG, 0, 1, 32'd0, 64'd0, 64'd0, 32'h7fffffff));
    cmd_q.push_back(make_cmd(ttt_pkg::OP_REG, 0, 0, 32'd50000, 64'd0, 64'd0, 32'd1));
    cmd_q.push_back(make_cmd(ttt_pkg::OP_REG, 15, 0, '1, 64'd30000, 64'd0, 32'h80000000));
    cmd_q.push_back(make_cmd(ttt_pkg::OP_REG, 3, 0, 32'd20000, 64'd5, 64'd0, '1));
    cmd_q.push_back(make_cmd(ttt_pkg::OP_REG, 4, 1, 32'd20000, '1, 64'h0, 32'd5));
    cmd_q.push_back(make_cmd(ttt_pkg::OP_REG, 5, 1, 32'd0, 64'd0, '1, 32'd6));
    cmd_q.push_back(make_cmd(ttt_pkg::OP_DEREG, 7, 0, 32'd0, 64'd0, 64'd0, 32'd0));
    cmd_q.push_back(make_cmd(ttt_pkg::OP_EXPIRE, 8, 0, 32'd0, 64'd0, 64'd0, 32'd0));
    cmd_q.push_back(make_cmd(ttt_pkg::OP_EXPIRE, 15, 0, 32'd0, 64'd0, 64'd0, 32'd0));
    cmd_q.push_back(make_cmd(ttt_pkg::OP_TICK, 0, 0, 32'd0, 64'd0, 64'd0, 32'd0));
    cmd_q.push_back(make_cmd(ttt_pkg::OP_TICK, 0, 0, 32'd0, 64'd0, 64'd0, 32'd0));
    cmd_q.push_back(make_cmd(ttt_pkg::OP_DEREG, 4, 0, 32'd0, 64'd0, 64'd0, 32'd0));
    cmd_q.push_back(make_cmd(ttt_pkg::OP_TICK, 0, 0, 32'd0, 64'd0, 64'd0, 32'd0));
    for (int i = 0; i < ttt_pkg::SLOTS; i++)
      cmd_q.push_back(make_cmd(ttt_pkg::OP_REG, i, i % 2, 32'd10000, 64'd0, 64'd0,
                               i * 1000 - 5));
    cmd_q.push_back(make_cmd(ttt_pkg::OP_TICK, 0, 0, 32'd0, 64'd0, 64'd0, 32'd0));
    drain();

    // Zero resolution rejects everything.
    write_res('0);
    for (int i = 0; i < 4; i++)
      cmd_q.push_back(make_cmd(i, 9, 0, 32'd0, 64'd0, 64'd0, 32'd0));
    drain();

    // Random phases across several resolutions, the extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_res(20'd1);
        1: write_res(20'd999999);
        2: write_res(20'hfffff);
        3: write_res(20'd10000);
        4: write_res(20'($urandom_range(1, 30000)));
        default: write_res(20'd4000);
      endcase
      if (ph == 5) quiet = 1'b1;
      for (int k = 0; k < 58; k++) cmd_q.push_back(rand_cmd());
      // In phase 3 the resolution rises over stored periods.
      if (ph == 3) begin
        drain();
        write_res(20'd70000);
        for (int k = 0; k < 10; k++) cmd_q.push_back(rand_cmd());
      end
      drain();
    end

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
